/* rtl/sparse_linear_classifier_scoring_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sparse linear classifier scorer
// Property wrappers; bodies are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SPARSE_LINEAR_CLASSIFIER_SCORING_TOP_MACROS_SVH
`define SPARSE_LINEAR_CLASSIFIER_SCORING_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SLCS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SLCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SLCS_ASSERT_IMPL(lbl, ante, cons)
`define SLCS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/slcs_pkg.sv */
// ----------------------------------------------------------------------------
// slcs_pkg
// Types and constants shared by the sparse linear classifier scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package slcs_pkg;

  localparam int TABLE_DEPTH = 65536;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_FEATURE = 1'b1;

  typedef struct packed {
    logic               func;
    logic [15:0]        index;
    logic signed [31:0] value;
    logic               last;
    logic               label_positive;
  } in_t;

  typedef struct packed {
    logic               predicted_positive;
    logic               correct;
    logic signed [47:0] score;
    logic [31:0]        correct_count;
    logic [31:0]        wrong_count;
  } out_t;

  typedef struct packed {
    logic signed [31:0] weight;
    logic signed [31:0] value;
    logic               last;
    logic               label_positive;
  } feat_t;

  typedef struct packed {
    logic clearing;
  } front_stat_t;

  typedef struct packed {
    logic [QLVL_W-1:0] level;
  } q_stat_t;

endpackage

`default_nettype wire

/* rtl/slcs_ram.sv */
// ----------------------------------------------------------------------------
// slcs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module slcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/slcs_front.sv */
// ----------------------------------------------------------------------------
// slcs_front
// Input side: clear pass, weight loads, weight lookup for feature items.
// ----------------------------------------------------------------------------
`default_nettype none

module slcs_front
  import slcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  input  wire q_stat_t     q_stat,
  output logic             push,
  output feat_t            push_data,
  output front_stat_t      stat
);

  logic                clearing;
  logic [TABLE_AW-1:0] clr_addr;
  logic                accept;
  logic                in_range;
  logic                ram_we;
  logic [TABLE_AW-1:0] ram_waddr;
  logic [31:0]         ram_wdata;
  logic                ram_re;
  logic [31:0]         ram_rdata;
  logic                r_valid;
  logic                r_in_range;
  logic signed [31:0]  r_value;
  logic                r_last;
  logic                r_label;

  assign in_stall = clearing ||
                    ((32'(q_stat.level) + 32'(r_valid)) >= 32'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign in_range = 32'(in_data.index) < 32'(TABLE_DEPTH);

  assign ram_we    = clearing || (accept && in_data.func == FUNC_LOAD && in_range);
  assign ram_waddr = clearing ? clr_addr : TABLE_AW'(in_data.index);
  assign ram_wdata = clearing ? 32'd0 : in_data.value;
  assign ram_re    = accept && in_data.func == FUNC_FEATURE;

  slcs_ram #(
    .WIDTH(32),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(TABLE_AW'(in_data.index)),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      r_valid  <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == TABLE_AW'(TABLE_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + 1'b1;
      end
      r_valid <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      r_in_range <= in_range;
      r_value    <= in_data.value;
      r_last     <= in_data.last;
      r_label    <= in_data.label_positive;
    end
  end

  assign push                     = r_valid;
  assign push_data.weight         = r_in_range ? signed'(ram_rdata) : 32'sd0;
  assign push_data.value          = r_value;
  assign push_data.last           = r_last;
  assign push_data.label_positive = r_label;
  assign stat.clearing            = clearing;

endmodule

`default_nettype wire

/* rtl/slcs_queue.sv */
// ----------------------------------------------------------------------------
// slcs_queue
// Short register FIFO of looked-up feature items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module slcs_queue
  import slcs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire feat_t push_data,
  input  wire logic  pop,
  output logic       q_valid,
  output feat_t      q_data,
  output q_stat_t    stat
);

  feat_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QLVL_W-1:0] level;
  logic              do_pop;

  assign q_valid = level != '0;
  assign do_pop  = pop && q_valid;
  assign q_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= (32'(wptr) == QUEUE_DEPTH - 1) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (32'(rptr) == QUEUE_DEPTH - 1) ? '0 : rptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  assign stat.level = level;

endmodule

`default_nettype wire

/* rtl/slcs_back.sv */
// ----------------------------------------------------------------------------
// slcs_back
// Multiply, saturating accumulate, bias subtract, tallies, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slcs_back
  import slcs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire feat_t              q_data,
  output logic                    pop,
  input  wire logic signed [31:0] bias,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_t                    out_data
);

  localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

  logic               advance;
  logic               p_valid;
  logic signed [63:0] p_prod;
  logic               p_last;
  logic               p_label;
  logic signed [47:0] sum;
  logic signed [48:0] sum_wide;
  logic signed [47:0] sum_next;
  logic               d_valid;
  logic signed [47:0] d_sum;
  logic               d_label;
  logic signed [48:0] score_wide;
  logic signed [47:0] score;
  logic               pred;
  logic               ok;
  logic [31:0]        right_tally;
  logic [31:0]        wrong_tally;
  logic [31:0]        right_next;
  logic [31:0]        wrong_next;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && q_valid;

  // floor of the Q32.32 product to Q32.16 is its upper 48 bits
  assign sum_wide = {sum[47], sum} + {p_prod[63], p_prod[63:16]};
  assign sum_next = (sum_wide[48] != sum_wide[47]) ?
                    (sum_wide[48] ? ACC_MIN : ACC_MAX) : sum_wide[47:0];

  assign score_wide = {d_sum[47], d_sum} - {{17{bias[31]}}, bias};
  assign score      = (score_wide[48] != score_wide[47]) ?
                      (score_wide[48] ? ACC_MIN : ACC_MAX) : score_wide[47:0];
  assign pred       = !score[47] && (score != 48'sd0);
  assign ok         = pred == d_label;
  assign right_next = (ok && right_tally != 32'hFFFF_FFFF) ? right_tally + 1'b1
                                                           : right_tally;
  assign wrong_next = (!ok && wrong_tally != 32'hFFFF_FFFF) ? wrong_tally + 1'b1
                                                            : wrong_tally;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid     <= 1'b0;
      d_valid     <= 1'b0;
      out_valid   <= 1'b0;
      sum         <= '0;
      right_tally <= '0;
      wrong_tally <= '0;
    end else if (advance) begin
      p_valid   <= pop;
      d_valid   <= p_valid && p_last;
      out_valid <= d_valid;
      if (p_valid) begin
        sum <= p_last ? 48'sd0 : sum_next;
      end
      if (d_valid) begin
        right_tally <= right_next;
        wrong_tally <= wrong_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pop) begin
        p_prod  <= q_data.value * q_data.weight;
        p_last  <= q_data.last;
        p_label <= q_data.label_positive;
      end
      if (p_valid) begin
        d_sum   <= sum_next;
        d_label <= p_label;
      end
      if (d_valid) begin
        out_data.predicted_positive <= pred;
        out_data.correct            <= ok;
        out_data.score              <= score;
        out_data.correct_count      <= right_next;
        out_data.wrong_count        <= wrong_next;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sparse_linear_classifier_scoring_top.sv */
// ----------------------------------------------------------------------------
// sparse_linear_classifier_scoring_top
// Linear SVM scorer for sparse Q16.16 feature vectors.
// Input channel in_valid/in_stall/in_data: func = load writes a weight into
// the table at index; func = feature multiplies value by the stored weight
// and accumulates. A feature item with last set closes the document and
// yields one item on out_valid/out_stall/out_data with score = sum - bias,
// the prediction, its match with the label and saturating tallies.
// cfg_wen/cfg_wdata writes the bias; the user must write it only while the
// block is idle, which the block itself does not enforce. Throughput: one
// input item per cycle while in_stall is low, loads and features alike; the
// table RAM takes one access per cycle, the multiply-accumulate one per cycle
// while the output is not stalled. The last feature goes through the table
// read at the edge that accepts it, then queue, multiply, accumulate and bias
// subtract into the output register. Reset: a clearing pass zeroes all 65536
// (TABLE_DEPTH) weight table entries with in_stall high; sum, tallies and
// bias go to zero. A stalled output holds its item; the back end halts and
// in_stall rises once queued items and a pending read fill the 4-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sparse_linear_classifier_scoring_top_macros.svh"

module sparse_linear_classifier_scoring_top
  import slcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_wen,
  input  wire logic [31:0] cfg_wdata
);

  logic signed [31:0] bias;
  logic               push;
  feat_t              push_data;
  logic               pop;
  logic               q_valid;
  feat_t              q_data;
  q_stat_t            q_stat;
  front_stat_t        f_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else if (cfg_wen) begin
      bias <= signed'(cfg_wdata);
    end
  end

  slcs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data),
    .stat     (f_stat)
  );

  slcs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .stat     (q_stat)
  );

  slcs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .bias     (bias),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  `SLCS_ASSERT_IMPL(a_no_accept_while_clearing, f_stat.clearing, in_stall)
  `SLCS_ASSERT_IMPL(a_queue_no_overflow, push, 32'(q_stat.level) < QUEUE_DEPTH)
  `SLCS_ASSERT_NEXT(a_accept_reaches_queue,
                    in_valid && !in_stall && in_data.func == FUNC_FEATURE, push)
  `SLCS_ASSERT_IMPL(a_pred_matches_score, out_valid,
                    out_data.predicted_positive ==
                    (!out_data.score[47] && out_data.score != 48'sd0))

endmodule

`default_nettype wire
